[hdl/assert_macros.svh]
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/sfcf_pkg.sv]
`default_nettype none

package sfcf_pkg;

   localparam int DELAY_DEPTH   = 32768;
   localparam int SAMPLE_WIDTH  = 24;
   localparam int CHANNEL_COUNT = 2;

   localparam int FRAME_CH   = 2;
   localparam int TDATA_W    = FRAME_CH * SAMPLE_WIDTH;
   localparam int ADDR_W     = $clog2(DELAY_DEPTH);
   localparam int DELAY_W    = 15;
   localparam int GAIN_W     = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int MIX_W      = 17;
   localparam int FRAC_W     = 15;
   localparam int FB_PROD_W  = SAMPLE_WIDTH + GAIN_W;
   localparam int MIX_PROD_W = SAMPLE_WIDTH + MIX_W + 1;
   localparam int WIDE_W     = MIX_PROD_W + 1;
   localparam int SAT_W      = WIDE_W - FRAC_W;

   localparam logic [ADDR_W-1:0] LAST_POS  = ADDR_W'(DELAY_DEPTH - 1);
   localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(DELAY_DEPTH);
   localparam logic [31:0]       DELAY_MAX = 32'(DELAY_DEPTH - 1);

   localparam logic signed [GAIN_W-1:0] FB_MAX = GAIN_W'(31129);
   localparam logic signed [GAIN_W-1:0] FB_MIN = GAIN_W'(-31129);
   localparam logic [MIX_W-1:0]         UNITY  = MIX_W'(32768);
   localparam logic signed [WIDE_W-1:0] RND_K  = WIDE_W'(16384);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE  = 2'd0,
      CSR_DELAY   = 2'd1,
      CSR_FB_GAIN = 2'd2,
      CSR_WET_MIX = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                      active;
      logic                      clear;
      logic [ADDR_W-1:0]         delay;
      logic signed [GAIN_W-1:0]  fb;
      logic [MIX_W-1:0]          wet;
      logic [MIX_W-1:0]          dry;
   } cfg_type;

   function automatic sample_type sat_sample(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-SAMPLE_WIDTH:0] top_bits;
      sample_type                  res;
      top_bits = v[SAT_W-1:SAMPLE_WIDTH-1];
      if ((&top_bits) || (~|top_bits)) begin
         res = v[SAMPLE_WIDTH-1:0];
      end else if (v[SAT_W-1]) begin
         res = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[hdl/sfcf_ram.sv]
`default_nettype none

module sfcf_ram #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15,
   parameter int DW    = 48
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

[hdl/sfcf_chan.sv]
`default_nettype none

module sfcf_chan import sfcf_pkg::*; (
   input  wire sample_type               x,
   input  wire sample_type               delayed,
   input  wire logic signed [GAIN_W-1:0] fb,
   input  wire logic [MIX_W-1:0]         wet,
   input  wire logic [MIX_W-1:0]         dry,
   output sample_type                    comb,
   output sample_type                    y
);

   logic signed [FB_PROD_W-1:0]  fb_prod;
   logic signed [WIDE_W-1:0]     fb_rnd;
   logic signed [SAT_W-1:0]      comb_sum;
   logic signed [MIX_W:0]        dry_s;
   logic signed [MIX_W:0]        wet_s;
   logic signed [MIX_PROD_W-1:0] dry_prod;
   logic signed [MIX_PROD_W-1:0] wet_prod;
   logic signed [WIDE_W-1:0]     mix_rnd;

   always_comb begin
      fb_prod  = delayed * fb;
      fb_rnd   = WIDE_W'(fb_prod) + RND_K;
      comb_sum = $signed(fb_rnd[WIDE_W-1:FRAC_W]) + SAT_W'(x);
      comb     = sat_sample(comb_sum);

      dry_s    = $signed({1'b0, dry});
      wet_s    = $signed({1'b0, wet});
      dry_prod = x * dry_s;
      wet_prod = delayed * wet_s;
      mix_rnd  = WIDE_W'(dry_prod) + WIDE_W'(wet_prod) + RND_K;
      y        = sat_sample($signed(mix_rnd[WIDE_W-1:FRAC_W]));
   end

endmodule

`default_nettype wire

[hdl/sfcf_csr.sv]
`default_nettype none

module sfcf_csr import sfcf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   logic                     wr;
   logic                     active_ff, active_in;
   logic [ADDR_W-1:0]        delay_ff, delay_in;
   logic signed [GAIN_W-1:0] fb_ff, fb_in;
   logic [MIX_W-1:0]         wet_ff, wet_in;
   logic [31:0]              dv;
   logic signed [GAIN_W-1:0] gv;
   logic [MIX_W-1:0]         mv;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      active_in = active_ff;
      delay_in  = delay_ff;
      fb_in     = fb_ff;
      wet_in    = wet_ff;
      dv        = 32'(csr_data[DELAY_W-1:0]);
      gv        = csr_data[GAIN_W-1:0];
      mv        = {1'b0, csr_data};
      if (wr) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE: begin
               active_in = csr_data[0];
            end
            CSR_DELAY: begin
               if (dv == 32'd0) begin
                  delay_in = ADDR_W'(1);
               end else if (dv > DELAY_MAX) begin
                  delay_in = LAST_POS;
               end else begin
                  delay_in = dv[ADDR_W-1:0];
               end
            end
            CSR_FB_GAIN: begin
               if (gv > FB_MAX) begin
                  fb_in = FB_MAX;
               end else if (gv < FB_MIN) begin
                  fb_in = FB_MIN;
               end else begin
                  fb_in = gv;
               end
            end
            CSR_WET_MIX: begin
               wet_in = (mv > UNITY) ? UNITY : mv;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         delay_ff  <= ADDR_W'(1);
         fb_ff     <= '0;
         wet_ff    <= '0;
      end else begin
         active_ff <= active_in;
         delay_ff  <= delay_in;
         fb_ff     <= fb_in;
         wet_ff    <= wet_in;
      end
   end

   always_comb begin
      cfg.active = active_ff;
      cfg.clear  = active_ff && !active_in;
      cfg.delay  = delay_ff;
      cfg.fb     = fb_ff;
      cfg.wet    = wet_ff;
      cfg.dry    = UNITY - wet_ff;
   end

endmodule

`default_nettype wire

[hdl/stereo_feedback_comb_filter.sv]
// Channel  Ports          Beat contents (low bit first)
// req      req_t*         tdata: left_in[23:0], right_in[47:24]
// rsp      rsp_t*         tdata: left_out[23:0], right_out[47:24]
// csr      csr_*          index 0 active, 1 delay, 2 feedback, 3 wet mix
//
// One frame per cycle while rsp is not stalled; each taken beat waits in stage 1
// during the delay memory read, then arithmetic loads the output register.
// A one-frame delay is served by forwarding the value being written.
// Reset and deactivation clear the store through a fill count: no sweep,
// the block is ready right after reset.
// A stalled rsp side holds the pipeline; req_tready drops while both stages are
// full and rsp_tready is low.
`default_nettype none
`include "assert_macros.svh"

module stereo_feedback_comb_filter import sfcf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [TDATA_W-1:0]    req_tdata,  // left_in, right_in
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [TDATA_W-1:0]    rsp_tdata,  // left_out, right_out
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;

   logic              req_accept;
   logic              s1_adv;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W:0]   wrap_sum;
   logic              mem_we;
   logic [TDATA_W-1:0] rd_data;
   logic [TDATA_W-1:0] comb_word;

   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic              full_ff, full_in;

   logic              s1_valid_ff, s1_valid_in;
   sample_type        s1_x_ff [FRAME_CH];
   sample_type        s1_x_in [FRAME_CH];
   logic [ADDR_W-1:0] s1_wa_ff, s1_wa_in;
   logic              s1_hit_ff, s1_hit_in;
   logic              s1_fwd_ff, s1_fwd_in;
   sample_type        s1_fwd_data_ff [FRAME_CH];
   sample_type        s1_fwd_data_in [FRAME_CH];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   sample_type dly  [FRAME_CH];
   sample_type comb [FRAME_CH];
   sample_type ych  [FRAME_CH];
   sample_type yout [FRAME_CH];

   sfcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      wrap_sum = {1'b0, pos_ff} + DEPTH_EXT - {1'b0, cfg.delay};
      rd_addr  = (pos_ff >= cfg.delay) ? (pos_ff - cfg.delay) : wrap_sum[ADDR_W-1:0];
   end

   assign mem_we = s1_adv && cfg.active;

   sfcf_ram #(
      .DEPTH (DELAY_DEPTH),
      .AW    (ADDR_W),
      .DW    (TDATA_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (s1_wa_ff),
      .wdata (comb_word),
      .re    (req_accept),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   for (genvar ch = 0; ch < FRAME_CH; ch++) begin : g_ch
      assign dly[ch] = s1_fwd_ff ? s1_fwd_data_ff[ch] :
                       s1_hit_ff ? rd_data[ch*SAMPLE_WIDTH +: SAMPLE_WIDTH] : '0;
      if (ch < CHANNEL_COUNT) begin : g_on
         sfcf_chan u_chan (
            .x       (s1_x_ff[ch]),
            .delayed (dly[ch]),
            .fb      (cfg.fb),
            .wet     (cfg.wet),
            .dry     (cfg.dry),
            .comb    (comb[ch]),
            .y       (ych[ch])
         );
      end else begin : g_off
         assign comb[ch] = '0;
         assign ych[ch]  = s1_x_ff[ch];
      end
      assign yout[ch] = cfg.active ? ych[ch] : s1_x_ff[ch];
      assign comb_word[ch*SAMPLE_WIDTH +: SAMPLE_WIDTH] = comb[ch];
   end

   // write position and fill state
   always_comb begin
      pos_in  = pos_ff;
      full_in = full_ff;
      if (cfg.clear) begin
         pos_in  = '0;
         full_in = 1'b0;
      end else if (req_accept && cfg.active) begin
         if (pos_ff == LAST_POS) begin
            pos_in  = '0;
            full_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_x_in     = s1_x_ff;
      s1_wa_in    = s1_wa_ff;
      s1_hit_in   = s1_hit_ff;
      s1_fwd_in   = s1_fwd_ff;
      s1_fwd_data_in = s1_fwd_data_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         for (int ch = 0; ch < FRAME_CH; ch++) begin
            s1_x_in[ch]        = req_tdata[ch*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            s1_fwd_data_in[ch] = comb[ch];
         end
         s1_wa_in  = pos_ff;
         s1_hit_in = full_ff || (rd_addr < pos_ff);
         s1_fwd_in = s1_adv && cfg.active && (rd_addr == s1_wa_ff);
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
         for (int ch = 0; ch < FRAME_CH; ch++) begin
            rsp_data_in[ch*SAMPLE_WIDTH +: SAMPLE_WIDTH] = yout[ch];
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         full_ff      <= full_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff        <= s1_x_in;
      s1_wa_ff       <= s1_wa_in;
      s1_hit_ff      <= s1_hit_in;
      s1_fwd_ff      <= s1_fwd_in;
      s1_fwd_data_ff <= s1_fwd_data_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLIES(a_no_write_idle, clock, reset, mem_we, cfg.active)
   `ASSERT_NEXT(a_clear_pos, clock, reset, cfg.clear, (pos_ff == '0) && !full_ff)
   `ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff && $stable(s1_wa_ff))

endmodule

`default_nettype wire
